FILE: design/event_channel_controller_unit_defines.svh
// Assertion macros shared by the event channel controller files
`ifndef EVENT_CHANNEL_CONTROLLER_UNIT_DEFINES_SVH
`define EVENT_CHANNEL_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define ECC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define ECC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ecc_pkg.sv
// Shared constants, types and helper functions of the event channel controller
package ecc_pkg;

  localparam int NUM_PORTS = 1024;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = (NUM_PORTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int PORT_W    = 10;
  localparam int CMD_W     = 3;
  localparam int CNT_W     = 32;
  localparam int CNT_AW    = $clog2(NUM_PORTS);

  localparam logic [CMD_W-1:0] CMD_MASK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UNMASK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RAISE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd4;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [CNT_AW-1:0] addr;
    logic [CNT_W-1:0]  wdata;
  } cnt_req_t;

  function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: design/event_channel_controller_unit.sv
// Event channel controller: pending/mask bitmaps, word selector and per-port counters
//
// Each transaction on the in_ channel is one command and yields exactly one result on the
// out_ channel. The pending and mask bitmaps sit in a 32-entry memory of {pending, mask}
// words, the port counters in a 1024-entry memory, both with registered reads.
// Mask, unmask, clear and raise read, modify and write back the bitmap word, then hand over
// the result; unused commands and out-of-range ports go straight to hand-over. A dispatch
// reads the bitmap word of each selected word in turn, skipping empty ones; when a port is
// delivered it reads its counter, increments it and writes it back. After reset the counter
// memory is cleared one entry a cycle; in_ready stays low until then, configuration writes
// are taken at any time. The output register lets a new transaction in while a result waits.
`include "event_channel_controller_unit_defines.svh"

module event_channel_controller_unit
  import ecc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [PORT_W-1:0] in_port,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_event_valid,
  output logic [PORT_W-1:0] out_event_port,
  output logic [CNT_W-1:0]  out_event_count,
  output logic              out_callback_request,
  output logic              out_upcall_pending,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_upcall_mask
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BM_RD,
    S_SCAN,
    S_SCAN_RD,
    S_CNT_RD,
    S_PUSH
  } state_t;

  state_t              state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [WIDX_W-1:0]   word_r, word_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic [NUM_WORDS-1:0] sel_r, sel_nxt;
  logic [NUM_WORDS-1:0] snap_r, snap_nxt;
  logic                flag_r, flag_nxt;
  logic                umask_r;
  logic [NUM_WORDS-1:0] bm_vld_r, bm_vld_nxt;
  logic                bm_q_vld_r;
  logic [2*WORD_BITS-1:0] bm_q_r;
  logic [CNT_AW-1:0]   cnt_addr_r, cnt_addr_nxt;

  logic                res_vld_r, res_vld_nxt;
  logic [PORT_W-1:0]   res_port_r, res_port_nxt;
  logic [CNT_W-1:0]    res_cnt_r, res_cnt_nxt;
  logic                res_cb_r, res_cb_nxt;
  logic                res_up_r, res_up_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_ev_r;
  logic [PORT_W-1:0]   out_port_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic                out_cb_r;
  logic                out_up_r;
  logic                out_load;

  logic [2*WORD_BITS-1:0] bm_mem [NUM_WORDS];
  logic                bm_rd;
  logic [WIDX_W-1:0]   bm_raddr;
  logic                bm_wr;
  logic [2*WORD_BITS-1:0] bm_wdata;

  cnt_req_t            cnt_req;
  logic [CNT_W-1:0]    cnt_rdata;
  logic                cnt_rdy;

  logic                in_acc;
  logic                port_ok;
  logic [WORD_BITS-1:0] pend_q, mask_q, bitm, pend_new, mask_new, active;
  logic                post_req, post_eff;
  logic [BIT_W-1:0]    hit_bit;
  logic [WIDX_W+BIT_W-1:0] hit_port;

  assign in_ready  = (state_r == S_IDLE) && cnt_rdy;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign port_ok   = 32'(in_port) < NUM_PORTS;

  assign pend_q   = bm_q_vld_r ? bm_q_r[2*WORD_BITS-1:WORD_BITS] : '0;
  assign mask_q   = bm_q_vld_r ? bm_q_r[WORD_BITS-1:0] : '1;
  assign bitm     = WORD_BITS'(1) << bit_r;
  assign active   = pend_q & ~mask_q;
  assign hit_bit  = lowest_bit(active);
  assign hit_port = {word_r, hit_bit};
  assign out_load = (state_r == S_PUSH) && (!out_valid_r || out_ready);

  ecc_cnt_store u_cnt_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cnt_req),
    .rdata (cnt_rdata),
    .done  (cnt_rdy)
  );

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    word_nxt     = word_r;
    bit_nxt      = bit_r;
    sel_nxt      = sel_r;
    snap_nxt     = snap_r;
    flag_nxt     = flag_r;
    bm_vld_nxt   = bm_vld_r;
    cnt_addr_nxt = cnt_addr_r;
    res_vld_nxt  = res_vld_r;
    res_port_nxt = res_port_r;
    res_cnt_nxt  = res_cnt_r;
    res_cb_nxt   = res_cb_r;
    res_up_nxt   = res_up_r;
    bm_rd        = 1'b0;
    bm_raddr     = word_r;
    bm_wr        = 1'b0;
    bm_wdata     = {pend_q, mask_q};
    cnt_req      = '0;
    pend_new     = pend_q;
    mask_new     = mask_q;
    post_req     = 1'b0;
    post_eff     = 1'b0;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_cmd;
          word_nxt = in_port[BIT_W +: WIDX_W];
          bit_nxt  = in_port[BIT_W-1:0];
          res_vld_nxt  = 1'b0;
          res_port_nxt = '0;
          res_cnt_nxt  = '0;
          res_cb_nxt   = 1'b0;
          res_up_nxt   = flag_r;
          if ((in_cmd inside {[CMD_MASK:CMD_RAISE]}) && port_ok) begin
            bm_rd     = 1'b1;
            bm_raddr  = in_port[BIT_W +: WIDX_W];
            state_nxt = S_BM_RD;
          end else if (in_cmd == CMD_DISPATCH) begin
            if (snap_r == '0) begin
              snap_nxt = sel_r;
              sel_nxt  = '0;
              flag_nxt = 1'b0;
            end
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_BM_RD: begin
        case (cmd_r)
          CMD_MASK: begin
            mask_new = mask_q | bitm;
          end
          CMD_UNMASK: begin
            mask_new = mask_q & ~bitm;
            post_req = (pend_q & bitm) != '0;
          end
          CMD_CLEAR: begin
            pend_new = pend_q & ~bitm;
          end
          default: begin
            if ((pend_q & bitm) == '0) begin
              pend_new = pend_q | bitm;
              post_req = (mask_q & bitm) == '0;
            end
          end
        endcase
        post_eff = post_req && !sel_r[word_r];
        if (post_eff) begin
          sel_nxt[word_r] = 1'b1;
          flag_nxt        = 1'b1;
        end
        bm_wr              = 1'b1;
        bm_wdata           = {pend_new, mask_new};
        bm_vld_nxt[word_r] = 1'b1;
        res_cb_nxt         = post_eff && !umask_r;
        res_up_nxt         = post_eff || flag_r;
        state_nxt          = S_PUSH;
      end
      S_SCAN: begin
        res_up_nxt = flag_r;
        if (snap_r == '0) begin
          state_nxt  = S_PUSH;
        end else begin
          word_nxt  = WIDX_W'(lowest_bit(WORD_BITS'(snap_r)));
          bm_rd     = 1'b1;
          bm_raddr  = WIDX_W'(lowest_bit(WORD_BITS'(snap_r)));
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (active == '0) begin
          snap_nxt[word_r] = 1'b0;
          state_nxt        = S_SCAN;
        end else begin
          bm_wr              = 1'b1;
          bm_wdata           = {pend_q & ~(WORD_BITS'(1) << hit_bit), mask_q};
          bm_vld_nxt[word_r] = 1'b1;
          res_vld_nxt        = 1'b1;
          res_port_nxt       = PORT_W'(hit_port);
          res_cnt_nxt        = '0;
          if (32'(hit_port) < NUM_PORTS) begin
            cnt_req.rd   = 1'b1;
            cnt_req.addr = CNT_AW'(hit_port);
            cnt_addr_nxt = CNT_AW'(hit_port);
            state_nxt    = S_CNT_RD;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_CNT_RD: begin
        cnt_req.wr    = 1'b1;
        cnt_req.addr  = cnt_addr_r;
        cnt_req.wdata = cnt_rdata + 1'b1;
        res_cnt_nxt   = cnt_rdata + 1'b1;
        state_nxt     = S_PUSH;
      end
      S_PUSH: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= '0;
      snap_r      <= '0;
      flag_r      <= 1'b0;
      umask_r     <= 1'b0;
      bm_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      snap_r      <= snap_nxt;
      flag_r      <= flag_nxt;
      bm_vld_r    <= bm_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        umask_r <= cfg_upcall_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    word_r     <= word_nxt;
    bit_r      <= bit_nxt;
    cnt_addr_r <= cnt_addr_nxt;
    res_vld_r  <= res_vld_nxt;
    res_port_r <= res_port_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_cb_r   <= res_cb_nxt;
    res_up_r   <= res_up_nxt;
    if (out_load) begin
      out_ev_r   <= res_vld_r;
      out_port_r <= res_port_r;
      out_cnt_r  <= res_cnt_r;
      out_cb_r   <= res_cb_r;
      out_up_r   <= res_up_r;
    end
  end

  always_ff @(posedge clk) begin
    if (bm_wr) begin
      bm_mem[word_r] <= bm_wdata;
    end
    if (bm_rd) begin
      bm_q_r     <= bm_mem[bm_raddr];
      bm_q_vld_r <= bm_vld_nxt[bm_raddr];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_event_valid      = out_ev_r;
  assign out_event_port       = out_port_r;
  assign out_event_count      = out_cnt_r;
  assign out_callback_request = out_cb_r;
  assign out_upcall_pending   = out_up_r;

  `ECC_ASSERT_NOW(a_accept_after_clear, in_valid && in_ready, cnt_rdy, "transaction taken during counter clear")
  `ECC_ASSERT_NOW(a_cb_implies_upcall, out_valid && out_callback_request, out_upcall_pending, "callback without upcall pending")
  `ECC_ASSERT_NEXT(a_snapshot_takes_sel, in_valid && in_ready && in_cmd == CMD_DISPATCH && snap_r == '0, sel_r == '0 && !flag_r, "selector not taken into snapshot")
  `ECC_ASSERT_NOW(a_no_bm_overlap, bm_rd, !bm_wr, "bitmap read and write in one cycle")

endmodule

FILE: design/ecc_cnt_store.sv
// Per-port event counter memory with a clearing sweep after reset
`include "event_channel_controller_unit_defines.svh"

module ecc_cnt_store
  import ecc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cnt_req_t         req,
  output logic [CNT_W-1:0] rdata,
  output logic             done
);

  logic [CNT_W-1:0] mem [NUM_PORTS];
  logic [CNT_AW:0]  clr_idx_r;
  logic [CNT_AW:0]  clr_idx_nxt;
  logic             done_r;
  logic             done_nxt;
  logic [CNT_W-1:0] rdata_r;

  always_comb begin
    clr_idx_nxt = clr_idx_r;
    done_nxt    = done_r;
    if (!done_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (32'(clr_idx_r) == NUM_PORTS - 1) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      done_r    <= 1'b0;
    end else begin
      clr_idx_r <= clr_idx_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!done_r) begin
      mem[clr_idx_r[CNT_AW-1:0]] <= '0;
    end else if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;
  assign done  = done_r;

  `ECC_ASSERT_NOW(a_no_access_in_clear, !done_r, !req.rd && !req.wr, "counter access during clear")
  `ECC_ASSERT_NEXT(a_done_sticky, done_r, done_r, "clear done dropped")
  `ECC_ASSERT_NEXT(a_clear_advances, !done_r, clr_idx_r == $past(clr_idx_r) + 1'b1, "clear stalled")

endmodule

FILE: tb/event_channel_controller_unit_tb.sv
// Self-checking testbench for the event channel controller with a built-in predictor
`timescale 1ns / 100ps

module event_channel_controller_unit_tb;
  import ecc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic              ev_valid;
    logic [PORT_W-1:0] ev_port;
    logic [CNT_W-1:0]  ev_count;
    logic              callback;
    logic              upcall;
  } evt_result_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_cmd = '0;
  logic [PORT_W-1:0] in_port = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_event_valid;
  logic [PORT_W-1:0] out_event_port;
  logic [CNT_W-1:0]  out_event_count;
  logic              out_callback_request;
  logic              out_upcall_pending;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_upcall_mask = 1'b0;

  logic [WORD_BITS-1:0] pend_model [NUM_WORDS];
  logic [WORD_BITS-1:0] mask_model [NUM_WORDS];
  logic [CNT_W-1:0]     count_model [NUM_PORTS];
  logic [WORD_BITS-1:0] sel_model;
  logic [WORD_BITS-1:0] snap_model;
  logic                 upcall_model;
  logic                 upcall_mask_model;

  evt_result_t expected_events [$];
  int          err_cnt = 0;
  int          stall_cycles = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;

  event_channel_controller_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_port              (in_port),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_event_valid      (out_event_valid),
    .out_event_port       (out_event_port),
    .out_event_count      (out_event_count),
    .out_callback_request (out_callback_request),
    .out_upcall_pending   (out_upcall_pending),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_upcall_mask      (cfg_upcall_mask)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned first_set_bit(logic [WORD_BITS-1:0] v);
    int unsigned idx;
    logic        hit;
    idx = 0;
    hit = 1'b0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i] && !hit) begin
        idx = i;
        hit = 1'b1;
      end
    end
    return idx;
  endfunction

  function automatic logic post_upcall(int unsigned w);
    if (sel_model[w]) begin
      return 1'b0;
    end
    sel_model[w] = 1'b1;
    upcall_model = 1'b1;
    return !upcall_mask_model;
  endfunction

  function automatic evt_result_t predict_event_result(logic [CMD_W-1:0] cmd,
                                                       logic [PORT_W-1:0] port);
    evt_result_t          r;
    int unsigned          w;
    int unsigned          b;
    int unsigned          p;
    logic [WORD_BITS-1:0] act;
    logic                 done;
    r = '0;
    w = port / WORD_BITS;
    b = port % WORD_BITS;
    done = 1'b0;
    case (cmd)
      CMD_MASK: begin
        mask_model[w][b] = 1'b1;
      end
      CMD_UNMASK: begin
        mask_model[w][b] = 1'b0;
        if (pend_model[w][b]) begin
          r.callback = post_upcall(w);
        end
      end
      CMD_CLEAR: begin
        pend_model[w][b] = 1'b0;
      end
      CMD_RAISE: begin
        if (!pend_model[w][b]) begin
          pend_model[w][b] = 1'b1;
          if (!mask_model[w][b]) begin
            r.callback = post_upcall(w);
          end
        end
      end
      CMD_DISPATCH: begin
        if (snap_model == '0) begin
          upcall_model = 1'b0;
          snap_model = sel_model;
          sel_model = '0;
        end
        while (snap_model != '0 && !done) begin
          w = first_set_bit(snap_model);
          act = pend_model[w] & ~mask_model[w];
          if (act == '0) begin
            snap_model[w] = 1'b0;
          end else begin
            b = first_set_bit(act);
            pend_model[w][b] = 1'b0;
            p = w * WORD_BITS + b;
            count_model[p] = count_model[p] + 1'b1;
            r.ev_valid = 1'b1;
            r.ev_port = PORT_W'(p);
            r.ev_count = count_model[p];
            done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.upcall = upcall_model;
    return r;
  endfunction

  task automatic reset_model();
    for (int i = 0; i < NUM_WORDS; i++) begin
      pend_model[i] = '0;
      mask_model[i] = '1;
    end
    for (int i = 0; i < NUM_PORTS; i++) begin
      count_model[i] = '0;
    end
    sel_model = '0;
    snap_model = '0;
    upcall_model = 1'b0;
    upcall_mask_model = 1'b0;
  endtask

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [PORT_W-1:0] port);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_port <= port;
    do @(posedge clk); while (!in_ready);
    expected_events.push_back(predict_event_result(cmd, port));
  endtask

  // hold the sender until every outstanding result has come back
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  task automatic write_upcall_mask(logic v);
    wait_results_done();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_upcall_mask <= v;
    do @(posedge clk); while (!cfg_ready);
    upcall_mask_model = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    evt_result_t exp_r;
    if (out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        err_cnt++;
        $display("%0t: result with nothing expected, expected none actual port %0h",
                 $time, out_event_port);
      end else begin
        exp_r = expected_events.pop_front();
        check_field("event_valid", 32'(exp_r.ev_valid), 32'(out_event_valid));
        check_field("event_port", 32'(exp_r.ev_port), 32'(out_event_port));
        check_field("event_count", exp_r.ev_count, out_event_count);
        check_field("callback_request", 32'(exp_r.callback), 32'(out_callback_request));
        check_field("upcall_pending", 32'(exp_r.upcall), 32'(out_upcall_pending));
      end
    end
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("event_channel_controller_unit_tb: errors");
    $finish;
  end

  task automatic test_idle_commands();
    send_cmd(CMD_DISPATCH, 10'd0);
    send_cmd(CMD_RSVD_A, 10'd1023);
    send_cmd(CMD_RSVD_B, 10'd0);
    send_cmd(CMD_RSVD_C, 10'd512);
  endtask

  task automatic test_masked_raise();
    send_cmd(CMD_RAISE, 10'd0);
    send_cmd(CMD_RAISE, 10'd0);
    send_cmd(CMD_UNMASK, 10'd0);
    send_cmd(CMD_DISPATCH, 10'd0);
    send_cmd(CMD_DISPATCH, 10'd0);
  endtask

  task automatic test_port_extremes();
    send_cmd(CMD_UNMASK, 10'd1023);
    send_cmd(CMD_RAISE, 10'd1023);
    send_cmd(CMD_MASK, 10'd1023);
    send_cmd(CMD_DISPATCH, 10'd1023);
    send_cmd(CMD_UNMASK, 10'd1023);
    send_cmd(CMD_DISPATCH, 10'd0);
  endtask

  task automatic test_word_skip();
    send_cmd(CMD_UNMASK, 10'd40);
    send_cmd(CMD_RAISE, 10'd40);
    send_cmd(CMD_UNMASK, 10'd70);
    send_cmd(CMD_RAISE, 10'd70);
    send_cmd(CMD_CLEAR, 10'd40);
    send_cmd(CMD_DISPATCH, 10'd0);
  endtask

  task automatic test_upcall_mask_cfg();
    write_upcall_mask(1'b1);
    send_cmd(CMD_RAISE, 10'd70);
    send_cmd(CMD_DISPATCH, 10'd0);
    write_upcall_mask(1'b0);
  endtask

  task automatic test_random_traffic(int n, int in_pct, int out_pct, logic umask);
    int unsigned       hot [3];
    int unsigned       roll;
    logic [CMD_W-1:0]  cmd;
    logic [PORT_W-1:0] port;
    write_upcall_mask(umask);
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    for (int i = 0; i < 3; i++) begin
      hot[i] = $urandom_range(0, NUM_WORDS - 1);
    end
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        cmd = CMD_MASK;
      end else if (roll < 32) begin
        cmd = CMD_UNMASK;
      end else if (roll < 40) begin
        cmd = CMD_CLEAR;
      end else if (roll < 68) begin
        cmd = CMD_RAISE;
      end else if (roll < 95) begin
        cmd = CMD_DISPATCH;
      end else if (roll < 97) begin
        cmd = CMD_RSVD_A;
      end else if (roll < 99) begin
        cmd = CMD_RSVD_B;
      end else begin
        cmd = CMD_RSVD_C;
      end
      if ($urandom_range(0, 4) == 0) begin
        port = PORT_W'($urandom_range(0, NUM_PORTS - 1));
      end else if ($urandom_range(0, 1) == 0) begin
        port = PORT_W'(hot[$urandom_range(0, 2)] * WORD_BITS + $urandom_range(0, 31));
      end else begin
        port = PORT_W'(hot[$urandom_range(0, 2)] * WORD_BITS + $urandom_range(0, 3));
      end
      send_cmd(cmd, port);
      if (i == n / 2) begin
        wait_results_done();
      end
    end
  endtask

  initial begin
    reset_model();
    in_idle_pct = 13;
    out_idle_pct = 81;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_upcall_mask(1'b0);
    test_idle_commands();
    test_masked_raise();
    test_port_extremes();
    test_word_skip();
    test_upcall_mask_cfg();
    test_random_traffic(700, 13, 81, 1'b0);
    test_random_traffic(700, 81, 13, 1'b1);
    test_random_traffic(600, 0, 0, 1'b0);
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("event_channel_controller_unit_tb: clean");
    end else begin
      $display("event_channel_controller_unit_tb: errors");
    end
    $finish;
  end

endmodule
